// ----- rtl/awsu_pkg.sv -----
// Shared constants for the acoustic wave stencil update block.
// No dependencies; used by the channel interfaces and the top level.
package awsu_pkg;

  // Grid and line delay geometry
  localparam int MAX_ROW_WIDTH = 16384;
  localparam int MIN_ROW_WIDTH = 3;
  localparam int LINE_DEPTH    = 2 * MAX_ROW_WIDTH + 1;
  localparam int PTR_W         = $clog2(LINE_DEPTH);
  localparam int ROW_W         = 15;
  localparam int WEFF_W        = $clog2(MAX_ROW_WIDTH + 1);
  localparam int SPAN_W        = WEFF_W + 1;

  // Field widths
  localparam int SMP_W  = 32;
  localparam int VEL_W  = 16;
  localparam int V2_W   = 2 * VEL_W;
  localparam int COEF_W = 48;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Z    = 2'd2;

  // Datapath widths
  localparam int LAP_W   = SMP_W + 2;
  localparam int SEG_W   = 17;
  localparam int COEF_H_W = COEF_W / 2;
  localparam int S_W     = 5 * SEG_W;
  localparam int ACC_W   = 118;
  localparam int MA_W    = V2_W + 1;
  localparam int MB_W    = SEG_W + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int FRAC_SH = COEF_W;

  // Sequencer lengths
  localparam int READ_STEPS = 5;
  localparam int S_STEPS    = 8;
  localparam int T_STEPS    = (S_W + SEG_W - 1) / SEG_W;

endpackage

// ----- rtl/awsu_if.sv -----
// Valid/ready channel interfaces for the stencil update block.
// Depends on awsu_pkg for the field widths.
interface awsu_in_if;
  import awsu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] wave_ahead;
  logic signed [SMP_W-1:0] wave_older;
  logic [VEL_W-1:0]        velocity;
  logic                    frame_start;

  modport source (output valid, wave_ahead, wave_older, velocity, frame_start, input ready);
  modport sink   (input valid, wave_ahead, wave_older, velocity, frame_start, output ready);
endinterface

interface awsu_out_if;
  import awsu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] wave_new;
  logic                    saturated;

  modport source (output valid, wave_new, saturated, input ready);
  modport sink   (input valid, wave_new, saturated, output ready);
endinterface

// ----- rtl/acoustic_wave_stencil_update.sv -----
// A cell of the first two rows of a plane (no result) is done in its accept cycle; a cell
// with a result passes READ, LAP, MUL_S, MUL_T and DONE before the output register loads.
// Items are not overlapped: a new item is taken only in IDLE, after four reads from the
// single-read-port line memory and 13 passes through the shared 33x18 multiplier.
// Reset (async, active low) clears the sequencer, pointers, cell count, output valid
// and configuration registers; the line memory is not cleared and holds garbage until written.
module acoustic_wave_stencil_update (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [awsu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [awsu_pkg::COEF_W-1:0]        cfg_data_i,
  awsu_in_if.sink                            in_i,
  awsu_out_if.source                         out_o
);
  import awsu_pkg::*;

  // Sequencer: read neighbours, form laplacians, S = cx*lx + cz*lz, T = v^2*S + base
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_LAP   = 6'b000100,
    ST_MUL_S = 6'b001000,
    ST_MUL_T = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]  row_width_q;
  logic [COEF_W-1:0] coef_x_q, coef_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_W'(MAX_ROW_WIDTH);
      coef_x_q    <= '0;
      coef_z_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_WIDTH: row_width_q <= cfg_data_i[ROW_W-1:0];
        REG_COEF_X:    coef_x_q    <= cfg_data_i;
        REG_COEF_Z:    coef_z_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Row width clamped to the supported range; span is two rows.
  logic [WEFF_W-1:0] w_eff;
  logic [SPAN_W-1:0] span;

  always_comb begin
    if (row_width_q < ROW_W'(MIN_ROW_WIDTH)) begin
      w_eff = WEFF_W'(MIN_ROW_WIDTH);
    end else if (32'(row_width_q) > 32'(MAX_ROW_WIDTH)) begin
      w_eff = WEFF_W'(MAX_ROW_WIDTH);
    end else begin
      w_eff = WEFF_W'(row_width_q);
    end
    span = {w_eff, 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Input accept, cell count, write pointer
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic              gate;
  logic [SPAN_W-1:0] cs_q, cs_d, cs_eff;
  logic [PTR_W-1:0]  wp_q, wp_d;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;

  always_comb begin
    cs_eff = in_i.frame_start ? '0 : cs_q;
    gate   = (cs_eff >= span);
    cs_d   = cs_q;
    wp_d   = wp_q;
    if (in_acc) begin
      cs_d = (cs_eff < span) ? cs_eff + 1'b1 : cs_eff;
      wp_d = (wp_q == PTR_W'(LINE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
  end

  // Per-item payload; the centre cell trails the stream by one row.
  logic [PTR_W-1:0]        item_wp_q;
  logic signed [SMP_W-1:0] down_q, older_q;
  logic [VEL_W-1:0]        vel_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_wp_q <= wp_q;
      down_q    <= in_i.wave_ahead;
      older_q   <= in_i.wave_older;
      vel_q     <= in_i.velocity;
    end
  end

  // ---------------------------------------------------------------------------
  // Line delay memory: written at the accept edge, then read four times.
  // The reads look 2..2*MAX_ROW_WIDTH entries back, never at the entry just
  // written, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  localparam int AW = PTR_W + 1;

  logic [SMP_W-1:0]  line_mem [LINE_DEPTH];
  logic [SMP_W-1:0]  rd_data_q;
  logic [SPAN_W-1:0] k_sel;
  logic [AW-1:0]     addr_sum;
  logic [PTR_W-1:0]  rd_addr;
  logic              mem_re;

  always_comb begin
    unique case (step_q[1:0])
      2'd0:    k_sel = SPAN_W'(w_eff);
      2'd1:    k_sel = SPAN_W'(w_eff) + 1'b1;
      2'd2:    k_sel = SPAN_W'(w_eff) - 1'b1;
      default: k_sel = span;
    endcase
    addr_sum = AW'(item_wp_q) + AW'(LINE_DEPTH) - AW'(k_sel);
    if (addr_sum >= AW'(LINE_DEPTH)) begin
      rd_addr = PTR_W'(addr_sum - AW'(LINE_DEPTH));
    end else begin
      rd_addr = PTR_W'(addr_sum);
    end
  end

  assign mem_re = (state_q == ST_READ) && (step_q < 3'(READ_STEPS - 1));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_mem[wp_q] <= in_i.wave_ahead;
    end
    if (mem_re) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  // Neighbour capture, in the cycle after each read: centre, left, right, up.
  logic signed [SMP_W-1:0] ctr_q, left_q, right_q, up_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      unique case (step_q)
        3'd1:    ctr_q   <= rd_data_q;
        3'd2:    left_q  <= rd_data_q;
        3'd3:    right_q <= rd_data_q;
        3'd4:    up_q    <= rd_data_q;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic: shared signed 33x18 multiplier, two accumulators
  // ---------------------------------------------------------------------------
  logic signed [LAP_W-1:0]  lap_x_q, lap_z_q;
  logic [V2_W-1:0]          v2_q;
  logic signed [S_W-1:0]    s_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic signed [LAP_W-1:0]  lap_x_d, lap_z_d, base;
  logic signed [ACC_W-1:0]  acc_init;

  always_comb begin
    lap_x_d  = LAP_W'(left_q) + LAP_W'(right_q) - (LAP_W'(ctr_q) <<< 1);
    lap_z_d  = LAP_W'(up_q) + LAP_W'(down_q) - (LAP_W'(ctr_q) <<< 1);
    base     = (LAP_W'(ctr_q) <<< 1) - LAP_W'(older_q);
    // 2^47 added up front gives round-to-nearest at the final shift
    acc_init = (ACC_W'(base) <<< FRAC_SH) + (ACC_W'(1) <<< (FRAC_SH - 1));
  end

  logic [COEF_W-1:0]        coef_sel;
  logic [COEF_H_W-1:0]      coef_half;
  logic signed [LAP_W-1:0]  lap_sel;
  logic [SEG_W-1:0]         seg;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [5:0]               s_sh;
  logic [6:0]               t_sh;
  logic signed [S_W-1:0]    s_add;
  logic signed [ACC_W-1:0]  t_add;

  always_comb begin
    // S pass: step[2] picks the axis, step[1] the coefficient half, step[0] the lap piece
    coef_sel  = step_q[2] ? coef_z_q : coef_x_q;
    coef_half = step_q[1] ? coef_sel[COEF_W-1:COEF_H_W] : coef_sel[COEF_H_W-1:0];
    lap_sel   = step_q[2] ? lap_z_q : lap_x_q;
    seg       = s_q[int'(step_q) * SEG_W +: SEG_W];
    if (state_q == ST_MUL_S) begin
      mul_a = {{(MA_W - COEF_H_W){1'b0}}, coef_half};
      mul_b = step_q[0] ? {lap_sel[LAP_W-1], lap_sel[LAP_W-1:SEG_W]}
                        : {1'b0, lap_sel[SEG_W-1:0]};
    end else begin
      // T pass: v^2 times one 17-bit segment of S, top segment signed
      mul_a = {1'b0, v2_q};
      mul_b = (step_q == 3'(T_STEPS - 1)) ? {seg[SEG_W-1], seg} : {1'b0, seg};
    end
    prod  = mul_a * mul_b;
    s_sh  = (step_q[1] ? 6'(COEF_H_W) : 6'd0) + (step_q[0] ? 6'(SEG_W) : 6'd0);
    t_sh  = 7'(SEG_W * int'(step_q));
    s_add = S_W'(prod) <<< s_sh;
    t_add = ACC_W'(prod) <<< t_sh;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LAP: begin
        lap_x_q <= lap_x_d;
        lap_z_q <= lap_z_d;
        v2_q    <= vel_q * vel_q;
        s_q     <= '0;
        acc_q   <= acc_init;
      end
      ST_MUL_S: s_q   <= s_q + s_add;
      ST_MUL_T: acc_q <= acc_q + t_add;
      default: ;
    endcase
  end

  // Rounded quotient is acc >> 48; it fits when bit 31 and all bits above it agree.
  localparam int HI_LSB = FRAC_SH + SMP_W - 1;

  logic [ACC_W-1:HI_LSB] acc_hi;
  logic                  fits;
  logic [SMP_W-1:0]      res_val;

  always_comb begin
    acc_hi = acc_q[ACC_W-1:HI_LSB];
    fits   = (&acc_hi) | ~(|acc_hi);
    if (fits) begin
      res_val = acc_q[FRAC_SH +: SMP_W];
    end else if (acc_q[ACC_W-1]) begin
      res_val = {1'b1, {(SMP_W - 1){1'b0}}};
    end else begin
      res_val = {1'b0, {(SMP_W - 1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a finished item while the next one is worked on
  // ---------------------------------------------------------------------------
  logic             out_vld_q;
  logic             out_free;
  logic             out_load;
  logic [SMP_W-1:0] out_wave_q;
  logic             out_sat_q;

  assign out_free = ~out_vld_q | out_o.ready;
  assign out_load = (state_q == ST_DONE) & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_wave_q <= res_val;
      out_sat_q  <= ~fits;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.wave_new  = out_wave_q;
  assign out_o.saturated = out_sat_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && gate) begin
          state_d = ST_READ;
          step_d  = '0;
        end
      end
      ST_READ: begin
        if (step_q == 3'(READ_STEPS - 1)) begin
          state_d = ST_LAP;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_LAP: begin
        state_d = ST_MUL_S;
        step_d  = '0;
      end
      ST_MUL_S: begin
        if (step_q == 3'(S_STEPS - 1)) begin
          state_d = ST_MUL_T;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_MUL_T: begin
        if (step_q == 3'(T_STEPS - 1)) begin
          state_d = ST_DONE;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      cs_q    <= '0;
      wp_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cs_q    <= cs_d;
      wp_q    <= wp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < PTR_W'(LINE_DEPTH))
    else $error("write pointer beyond line depth");

  a_edge_row_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !gate) |=> (state_q == ST_IDLE))
    else $error("edge-row item did not finish in its accept cycle");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a finished computation");

  a_rd_no_alias: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (rd_addr != item_wp_q))
    else $error("neighbour read hit the entry written by this item");

endmodule
